// ----- rtl/qes_pkg.sv -----
// Package: shared constants, codes and the command type for the quadrature encoder speed block.
`default_nettype none
package qes_pkg;
    localparam int TIMER_WIDTH = 16;
    localparam int COUNT_WIDTH = 32;
    localparam int CPR_WIDTH   = 16;
    localparam int SCALE_WIDTH = 32;
    localparam int DEN_WIDTH   = TIMER_WIDTH + CPR_WIDTH;
    localparam int DIV_STEPS   = SCALE_WIDTH;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int OUT_WIDTH   = 104;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_A    = 2'd1;
    localparam logic [1:0] MODE_B    = 2'd2;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd3;

    localparam logic REG_CPR   = 1'b0;
    localparam logic REG_SCALE = 1'b1;

    localparam logic [CPR_WIDTH-1:0]   CPR_RESET   = CPR_WIDTH'(1024);
    localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = SCALE_WIDTH'(65536);

    typedef struct packed {
        logic accept;
        logic load_den;
        logic div_step;
        logic load_out;
    } qes_cmd_t;
endpackage
`default_nettype wire

// ----- rtl/quadrature_encoder_speed_top.sv -----
// Top level: quadrature encoder decoder with period-based Q16.16 speed output.
// An accepted input passes the multiply state, the 32-step bit-serial restoring divider and
// the done state before its result is offered on m_tvalid; no new input is taken meanwhile.
// The next input is taken while a finished result still waits on the output register.
// Reset (aresetn, synchronous, active low) clears encoder state and valid flags
// and restores the config defaults.
`default_nettype none
module quadrature_encoder_speed_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,  // [0] pin_level
    input  wire logic [1:0]                      s_tuser,  // [1:0] mode
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [31:0] a_edges, [63:32] b_edges, [65:64] turn_sense, [97:66] shaft_speed
    output logic [qes_pkg::OUT_WIDTH-1:0]        m_tdata,
    input  wire logic                            cfg_wr_en,
    input  wire logic                            cfg_index,
    input  wire logic [qes_pkg::SCALE_WIDTH-1:0] cfg_wdata
);
    qes_pkg::qes_cmd_t cmd;

    qes_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    qes_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .mode      (s_tuser),
        .pin_level (s_tdata[0]),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .out_data  (m_tdata)
    );
endmodule
`default_nettype wire

// ----- rtl/qes_ctrl.sv -----
// Controller: sequences state update, multiply, bit-serial divide and output transfer.
`default_nettype none
module qes_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic             m_tready,
    output logic                  m_tvalid,
    output qes_pkg::qes_cmd_t     cmd
);
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                         state_reg;
    logic [qes_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic                           m_tvalid_reg;
    logic                           out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd          = '0;
        cmd.accept   = (state_reg == ST_IDLE) && s_tvalid;
        cmd.load_den = (state_reg == ST_MUL);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.load_out = (state_reg == ST_DONE) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == qes_pkg::DIV_CNT_W'(qes_pkg::DIV_STEPS - 1)) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/qes_datapath.sv -----
// Datapath: encoder state, configuration, span multiply, restoring divider and output register.
`default_nettype none
module qes_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire qes_pkg::qes_cmd_t                 cmd,
    input  wire logic [1:0]                        mode,
    input  wire logic                              pin_level,
    input  wire logic                              cfg_wr_en,
    input  wire logic                              cfg_index,
    input  wire logic [qes_pkg::SCALE_WIDTH-1:0]   cfg_wdata,
    output logic [qes_pkg::OUT_WIDTH-1:0]          out_data
);
    localparam int TW = qes_pkg::TIMER_WIDTH;
    localparam int CW = qes_pkg::COUNT_WIDTH;
    localparam int DW = qes_pkg::DEN_WIDTH;
    localparam int SW = qes_pkg::SCALE_WIDTH;

    logic [qes_pkg::CPR_WIDTH-1:0] cpr_reg;
    logic [SW-1:0]                 scale_reg;
    logic                          a_level_reg;
    logic                          b_level_reg;
    logic [TW-1:0]                 elapsed_reg;
    logic [TW-1:0]                 period_reg;
    logic [CW-1:0]                 a_count_reg;
    logic [CW-1:0]                 b_count_reg;
    logic [1:0]                    dir_reg;
    logic [DW-1:0]                 den_reg;
    logic [DW-1:0]                 rem_reg;
    logic [SW-1:0]                 quo_reg;
    logic [qes_pkg::OUT_WIDTH-1:0] out_reg;

    logic [TW-1:0] span;
    logic [DW:0]   trial;
    logic          fits;
    logic [SW-1:0] mag;
    logic [31:0]   speed;

    assign span  = (period_reg > elapsed_reg) ? period_reg : elapsed_reg;
    assign trial = {rem_reg, quo_reg[SW-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb begin
        if (quo_reg[SW-1] && (quo_reg[SW-2:0] != '0)) begin
            mag = {1'b1, {(SW-1){1'b0}}};
        end else begin
            mag = quo_reg;
        end
        case (dir_reg)
            qes_pkg::DIR_FWD: speed = mag[SW-1] ? 32'h7FFF_FFFF : 32'(mag);
            qes_pkg::DIR_REV: speed = 32'(-mag);
            default:          speed = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpr_reg     <= qes_pkg::CPR_RESET;
            scale_reg   <= qes_pkg::SCALE_RESET;
            a_level_reg <= 1'b0;
            b_level_reg <= 1'b0;
            elapsed_reg <= '0;
            period_reg  <= '0;
            a_count_reg <= '0;
            b_count_reg <= '0;
            dir_reg     <= qes_pkg::DIR_NONE;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    qes_pkg::REG_CPR:   cpr_reg   <= cfg_wdata[qes_pkg::CPR_WIDTH-1:0];
                    qes_pkg::REG_SCALE: scale_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.accept) begin
                case (mode)
                    qes_pkg::MODE_TICK: begin
                        if (elapsed_reg != '1) begin
                            elapsed_reg <= elapsed_reg + 1'b1;
                        end
                    end
                    qes_pkg::MODE_A: begin
                        a_level_reg <= pin_level;
                        if (pin_level) begin
                            period_reg  <= elapsed_reg;
                            elapsed_reg <= '0;
                        end
                        if (pin_level ^ b_level_reg) begin
                            a_count_reg <= a_count_reg + 1'b1;
                            dir_reg     <= qes_pkg::DIR_FWD;
                        end else begin
                            a_count_reg <= a_count_reg - 1'b1;
                            dir_reg     <= qes_pkg::DIR_REV;
                        end
                    end
                    qes_pkg::MODE_B: begin
                        b_level_reg <= pin_level;
                        if (pin_level ~^ a_level_reg) begin
                            b_count_reg <= b_count_reg + 1'b1;
                            dir_reg     <= qes_pkg::DIR_FWD;
                        end else begin
                            b_count_reg <= b_count_reg - 1'b1;
                            dir_reg     <= qes_pkg::DIR_REV;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_den) begin
            den_reg <= DW'(span * cpr_reg);
            rem_reg <= '0;
            quo_reg <= scale_reg;
        end else if (cmd.div_step) begin
            rem_reg <= fits ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            quo_reg <= {quo_reg[SW-2:0], fits};
        end
        if (cmd.load_out) begin
            out_reg <= {6'd0, speed, dir_reg, 32'($signed(b_count_reg)),
                        32'($signed(a_count_reg))};
        end
    end

    assign out_data = out_reg;
endmodule
`default_nettype wire

// ----- test/quadrature_encoder_speed_top_test.sv -----
// Testbench for quadrature_encoder_speed_top: table-driven and random encoder traffic vs. a predictor.
`timescale 1ns / 1ps
module quadrature_encoder_speed_top_test;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_CYCLES  = 400;
    localparam int SCRIPT_LEN   = 24;
    localparam int PHASE_ITEMS  = 310;

    typedef struct packed {
        logic signed [31:0] a_edges;
        logic signed [31:0] b_edges;
        logic [1:0]         turn_sense;
        logic signed [31:0] shaft_speed;
    } readout_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic        pin_level;
        logic [31:0] reps;
        logic        typed_in;
        readout_t    want;
    } step_row_t;

    localparam readout_t NO_WANT = '0;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata   = '0;  // [0] pin_level
    logic [1:0]                      s_tuser   = '0;  // [1:0] mode
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    // [31:0] a_edges, [63:32] b_edges, [65:64] turn_sense, [97:66] shaft_speed
    logic [qes_pkg::OUT_WIDTH-1:0]   m_tdata;
    logic                            cfg_wr_en = 1'b0;
    logic                            cfg_index = qes_pkg::REG_CPR;
    logic [qes_pkg::SCALE_WIDTH-1:0] cfg_wdata = '0;

    // predictor copy of the encoder state and registers
    logic [qes_pkg::CPR_WIDTH-1:0]   cpr_reg;
    logic [qes_pkg::SCALE_WIDTH-1:0] scale_reg;
    logic                            enc_a_lvl, enc_b_lvl;
    logic [qes_pkg::TIMER_WIDTH-1:0] tick_count, period_ticks;
    logic [31:0]                     a_edge_cnt, b_edge_cnt;
    logic [1:0]                      heading;

    readout_t  pending_readouts[$];
    step_row_t script [SCRIPT_LEN];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_ask     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int quiet        = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int mismatches   = 0;

    quadrature_encoder_speed_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void count_edge(inout logic [31:0] cnt, input logic fwd);
        if (fwd) begin
            cnt = cnt + 32'd1;
            heading = qes_pkg::DIR_FWD;
        end else begin
            cnt = cnt - 32'd1;
            heading = qes_pkg::DIR_REV;
        end
    endfunction

    function automatic readout_t advance_encoder(input logic [1:0] mode, input logic lvl);
        readout_t                        r;
        logic [qes_pkg::TIMER_WIDTH-1:0] span;
        logic [63:0]                     den;
        logic [63:0]                     mag;
        case (mode)
            qes_pkg::MODE_TICK: begin
                if (tick_count != '1)
                    tick_count = tick_count + 1'b1;
            end
            qes_pkg::MODE_A: begin
                enc_a_lvl = lvl;
                if (lvl) begin
                    period_ticks = tick_count;
                    tick_count = '0;
                    count_edge(a_edge_cnt, !enc_b_lvl);
                end else begin
                    count_edge(a_edge_cnt, enc_b_lvl);
                end
            end
            qes_pkg::MODE_B: begin
                enc_b_lvl = lvl;
                if (lvl)
                    count_edge(b_edge_cnt, enc_a_lvl);
                else
                    count_edge(b_edge_cnt, !enc_a_lvl);
            end
            default: ;
        endcase
        span = (period_ticks > tick_count) ? period_ticks : tick_count;
        den = 64'(span) * 64'(cpr_reg);
        if (den == 64'd0)
            mag = 64'h8000_0000;
        else
            mag = 64'(scale_reg) / den;
        if (mag > 64'h8000_0000)
            mag = 64'h8000_0000;
        r.a_edges = a_edge_cnt;
        r.b_edges = b_edge_cnt;
        r.turn_sense = heading;
        if (heading == qes_pkg::DIR_NONE)
            r.shaft_speed = '0;
        else if (heading == qes_pkg::DIR_FWD)
            r.shaft_speed = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        else
            r.shaft_speed = 32'd0 - mag[31:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch on %s: expected %h, got %h (result %0d)", what, want, got,
                 results_seen);
        mismatches++;
    endtask

    // result checker
    always @(posedge aclk) begin
        readout_t want;
        readout_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.a_edges     = m_tdata[31:0];
            got.b_edges     = m_tdata[63:32];
            got.turn_sense  = m_tdata[65:64];
            got.shaft_speed = m_tdata[97:66];
            if (pending_readouts.size() == 0) begin
                report_mismatch("unexpected transfer, a_edges", 32'd0, got.a_edges);
            end else begin
                want = pending_readouts.pop_front();
                if (got.a_edges !== want.a_edges)
                    report_mismatch("a_edges", want.a_edges, got.a_edges);
                if (got.b_edges !== want.b_edges)
                    report_mismatch("b_edges", want.b_edges, got.b_edges);
                if (got.turn_sense !== want.turn_sense)
                    report_mismatch("turn_sense", 32'(want.turn_sense), 32'(got.turn_sense));
                if (got.shaft_speed !== want.shaft_speed)
                    report_mismatch("shaft_speed", want.shaft_speed, got.shaft_speed);
            end
            results_seen++;
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(negedge aclk) begin
        if (hold_seen != hold_ask) begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("no transfer for %0d cycles, giving up", QUIET_LIMIT);
            $display("[quadrature_encoder_speed_top] ERROR");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // called just after a falling edge; returns just after a falling edge, once the item has been accepted
    task automatic offer(input logic [1:0] mode, input logic lvl,
                         input logic typed_in = 1'b0, input readout_t typed = NO_WANT);
        int       gap;
        readout_t predicted;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {7'd0, lvl};
        do @(posedge aclk); while (!s_tready);
        predicted = advance_encoder(mode, lvl);
        pending_readouts.push_back(typed_in ? typed : predicted);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_readouts.size() != 0)
            @(negedge aclk);
    endtask

    task automatic reconfigure(input logic [qes_pkg::CPR_WIDTH-1:0] cpr,
                               input logic [31:0] scale,
                               input int tx_pct, input int rx_pct);
        drain();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= qes_pkg::REG_CPR;
        cfg_wdata <= 32'(cpr);
        @(negedge aclk);
        cfg_index <= qes_pkg::REG_SCALE;
        cfg_wdata <= scale;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cpr_reg = cpr;
        scale_reg = scale;
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        @(negedge aclk);
    endtask

    // mostly clean quadrature motion with tick bursts, plus noise and repeated levels
    task automatic encoder_traffic(input int count);
        int         sent;
        int         pick;
        int         burst;
        logic       fwd;
        logic       heading_fwd;
        logic [1:0] mode;
        sent = 0;
        heading_fwd = 1'($urandom_range(1));
        while (sent < count) begin
            pick = $urandom_range(99);
            if ($urandom_range(99) < 4)
                heading_fwd = !heading_fwd;
            if (pick < 35) begin
                burst = ($urandom_range(9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
                repeat (burst) offer(qes_pkg::MODE_TICK, 1'($urandom_range(1)));
                sent += burst;
            end else if (pick < 85) begin
                fwd = ($urandom_range(9) < 8) ? heading_fwd : !heading_fwd;
                if ((enc_a_lvl == enc_b_lvl) == fwd)
                    offer(qes_pkg::MODE_A, !enc_a_lvl);
                else
                    offer(qes_pkg::MODE_B, !enc_b_lvl);
                sent++;
            end else if (pick < 93) begin
                mode = 2'($urandom_range(3));
                offer(mode, 1'($urandom_range(1)));
                if (mode != MODE_UNUSED)
                    sent++;
            end else begin
                if ($urandom_range(1))
                    offer(qes_pkg::MODE_A, enc_a_lvl);
                else
                    offer(qes_pkg::MODE_B, enc_b_lvl);
                sent++;
            end
        end
    endtask

    initial begin
        cpr_reg      = qes_pkg::CPR_RESET;
        scale_reg    = qes_pkg::SCALE_RESET;
        enc_a_lvl    = 1'b0;
        enc_b_lvl    = 1'b0;
        tick_count   = '0;
        period_ticks = '0;
        a_edge_cnt   = '0;
        b_edge_cnt   = '0;
        heading      = qes_pkg::DIR_NONE;

        script[0]  = '{qes_pkg::MODE_TICK, 1'b0, 32'd1, 1'b1,
                       '{32'sd0, 32'sd0, qes_pkg::DIR_NONE, 32'sd0}};
        script[1]  = '{MODE_UNUSED,        1'b1, 32'd1, 1'b1,
                       '{32'sd0, 32'sd0, qes_pkg::DIR_NONE, 32'sd0}};
        script[2]  = '{qes_pkg::MODE_A,    1'b1, 32'd1, 1'b0, NO_WANT};
        // zero denominator: repeated rising A clears the period
        script[3]  = '{qes_pkg::MODE_A,    1'b1, 32'd1, 1'b1,
                       '{32'sd2, 32'sd0, qes_pkg::DIR_FWD, 32'h7FFF_FFFF}};
        script[4]  = '{qes_pkg::MODE_A,    1'b0, 32'd1, 1'b1,
                       '{32'sd1, 32'sd0, qes_pkg::DIR_REV, 32'h8000_0000}};
        script[5]  = '{qes_pkg::MODE_B,    1'b0, 32'd1, 1'b1,
                       '{32'sd1, 32'sd1, qes_pkg::DIR_FWD, 32'h7FFF_FFFF}};
        script[6]  = '{qes_pkg::MODE_B,    1'b1, 32'd1, 1'b0, NO_WANT};
        script[7]  = '{qes_pkg::MODE_B,    1'b0, 32'd1, 1'b0, NO_WANT};
        script[8]  = '{MODE_UNUSED,        1'b0, 32'd1, 1'b0, NO_WANT};
        script[9]  = '{qes_pkg::MODE_TICK, 1'b0, 32'd5, 1'b0, NO_WANT};
        script[10] = '{qes_pkg::MODE_A,    1'b1, 32'd1, 1'b0, NO_WANT};
        script[11] = '{qes_pkg::MODE_B,    1'b0, 32'd1, 1'b0, NO_WANT};
        script[12] = '{qes_pkg::MODE_A,    1'b0, 32'd1, 1'b0, NO_WANT};
        script[13] = '{qes_pkg::MODE_B,    1'b1, 32'd1, 1'b0, NO_WANT};
        // long tick run stretches the span past the captured period
        script[14] = '{qes_pkg::MODE_TICK, 1'b1, 32'd40, 1'b0, NO_WANT};
        script[15] = '{MODE_UNUSED,        1'b1, 32'd1, 1'b0, NO_WANT};
        script[16] = '{qes_pkg::MODE_A,    1'b1, 32'd1, 1'b0, NO_WANT};
        script[17] = '{qes_pkg::MODE_TICK, 1'b0, 32'd3, 1'b0, NO_WANT};
        script[18] = '{qes_pkg::MODE_B,    1'b0, 32'd1, 1'b0, NO_WANT};
        script[19] = '{qes_pkg::MODE_A,    1'b0, 32'd1, 1'b0, NO_WANT};
        script[20] = '{qes_pkg::MODE_B,    1'b1, 32'd1, 1'b0, NO_WANT};
        script[21] = '{qes_pkg::MODE_A,    1'b1, 32'd1, 1'b0, NO_WANT};
        script[22] = '{qes_pkg::MODE_A,    1'b0, 32'd1, 1'b0, NO_WANT};
        script[23] = '{qes_pkg::MODE_B,    1'b0, 32'd1, 1'b0, NO_WANT};

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < SCRIPT_LEN; i++)
            repeat (script[i].reps)
                offer(script[i].mode, script[i].pin_level, script[i].typed_in, script[i].want);

        // saturating quotient
        reconfigure(16'd1, 32'hFFFF_FFFF, 0, 0);
        encoder_traffic(PHASE_ITEMS);

        reconfigure(16'd65535, 32'd0, 56, 0);
        encoder_traffic(PHASE_ITEMS);

        // counts per rotation of zero
        reconfigure(16'd0, $urandom, 0, 56);
        encoder_traffic(PHASE_ITEMS);

        reconfigure(16'($urandom_range(1, 64)), $urandom, 19, 19);
        encoder_traffic(PHASE_ITEMS);

        // long receiver hold-off, then a pause until everything is back
        reconfigure(16'($urandom_range(1, 4096)), $urandom, 0, 0);
        encoder_traffic(120);
        hold_ask++;
        encoder_traffic(30);
        drain();
        encoder_traffic(180);

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d encoder events and %0d checked results over six register settings,",
                 items_sent, results_seen);
        $display("including zero and maximal scaling, zero counts per rotation and stalls on both sides");
        if (mismatches == 0)
            $display("[quadrature_encoder_speed_top] OK");
        else
            $display("[quadrature_encoder_speed_top] ERROR");
        $finish;
    end
endmodule
